[sv/rtss_pkg.sv]
// rtss_pkg: shared types and codes of the record table block
// record layout, cell control word, mode and status codes; no dependencies
`timescale 1ns / 1ps
package rtss_pkg;

  typedef struct packed {
    logic [63:0]        code;
    logic [63:0]        name_first;
    logic [63:0]        name_middle;
    logic [31:0]        name_tail;
    logic signed [39:0] pay;
    logic signed [39:0] extra;
    logic signed [40:0] total;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_ROTATE = 2'd2,
    CELL_SORT   = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;  // odd-even sort phase
    logic     keep;   // rotate the head record back to the tail
  } cell_ctl_t;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_LIST   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_LIST      = 3'd4;

endpackage

[sv/rtss_cell.sv]
// rtss_cell: one table slot of the cell chain
// loads, rotates toward slot zero, or swaps with a neighbor; uses rtss_pkg
`timescale 1ns / 1ps
module rtss_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic              clk_i,
  input  rtss_pkg::cell_ctl_t ctl_i,
  input  logic [CntW-1:0]   n_i,
  input  rtss_pkg::rec_t    new_i,
  input  rtss_pkg::rec_t    head_i,
  input  rtss_pkg::rec_t    left_i,
  input  rtss_pkg::rec_t    right_i,
  output rtss_pkg::rec_t    rec_o
);
  import rtss_pkg::*;

  localparam logic [CntW-1:0] MyIdx  = CntW'(Idx);
  localparam logic            IsOdd  = 1'(Idx % 2);
  localparam bit              HasLft = (Idx > 0);

  rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    unique case (ctl_i.op)
      CELL_HOLD: rec_d = rec_q;
      CELL_LOAD: begin
        if (MyIdx == n_i) rec_d = new_i;
      end
      CELL_ROTATE: begin
        if (ctl_i.keep && (MyIdx == n_i - CntW'(1))) rec_d = head_i;
        else rec_d = right_i;
      end
      CELL_SORT: begin
        if (IsOdd == ctl_i.phase) begin
          // lower slot of the pair: take the right record if it is strictly larger
          if ((MyIdx + CntW'(1) < n_i) && ($signed(rec_q.total) < $signed(right_i.total)))
            rec_d = right_i;
        end else if (HasLft && (MyIdx < n_i) &&
                     ($signed(left_i.total) < $signed(rec_q.total))) begin
          rec_d = left_i;
        end
      end
      default: rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

[sv/record_table_search_remove_sort_top.sv]
// record_table_search_remove_sort_top: keyed record table with descending sort
// chain of rtss_cell slots plus a small sequencer; uses rtss_pkg and rtss_cell
//
// channel  | dir | signals                        | beat carries
// ---------+-----+--------------------------------+-----------------------------
// s_axis   | in  | tvalid tready tdata tuser      | one command (mode in tuser)
// m_axis   | out | tvalid tready tdata tuser tlast| one result (status in tuser)
//
// append loads the record into the next free slot; find and remove rotate
// the table once; list runs n odd-even transposition phases in the cells,
// then rotates it out one beat per cycle unless stalled; n = entries held
// commands are taken only while the sequencer is idle; a result beat waiting
// in the output register does not block the next command
// downstream stalls freeze the rotation; reset clears control, not the table
`timescale 1ns / 1ps
module record_table_search_remove_sort_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_code[63:0] name_first[127:64] name_middle[191:128] name_tail[223:192]
  // pay_in[263:224] extra_in[303:264]
  input  logic [303:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_code[63:0] out_name_first[127:64] out_name_middle[191:128]
  // out_name_tail[223:192] pay_out[263:224] extra_out[303:264]
  // income_total[344:304], zero filled above
  output logic [351:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import rtss_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_SORT = 5'b00100,
    S_EMIT = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] k_q, k_d;        // step counter
  logic [CntW-1:0] tot_q, tot_d;    // steps in this scan
  logic [1:0]      mode_q, mode_d;
  logic            found_q, found_d;
  logic [63:0]     key_q;
  logic [159:0]    nkey_q;          // name key, first part highest
  rec_t            res_q, res_d;    // record reported by the pending result
  logic [2:0]      rst_st_q, rst_st_d;

  // output register
  logic            ov_q, ov_d;
  rec_t            orec_q, orec_d;
  logic [2:0]      ost_q, ost_d;
  logic            olast_q, olast_d;

  cell_ctl_t       ctl;
  rec_t            new_rec;
  rec_t            recs [TABLE_DEPTH];
  rec_t            head;
  logic            s_fire, out_free, match, hit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;
  assign head          = recs[0];

  // record built from the input beat, total widened by one bit
  always_comb begin
    new_rec.code        = s_axis_tdata[63:0];
    new_rec.name_first  = s_axis_tdata[127:64];
    new_rec.name_middle = s_axis_tdata[191:128];
    new_rec.name_tail   = s_axis_tdata[223:192];
    new_rec.pay         = s_axis_tdata[263:224];
    new_rec.extra       = s_axis_tdata[303:264];
    new_rec.total       = 41'($signed(s_axis_tdata[263:224])) +
                          41'($signed(s_axis_tdata[303:264]));
  end

  // the chain of slots
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rec_t lft, rgt;
    if (i > 0) begin : g_l
      assign lft = recs[i-1];
    end else begin : g_l0
      assign lft = '0;
    end
    if (i + 1 < TABLE_DEPTH) begin : g_r
      assign rgt = recs[i+1];
    end else begin : g_rn
      assign rgt = '0;
    end
    rtss_cell #(.Idx(i), .CntW(CntW)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .n_i    (n_q),
      .new_i  (new_rec),
      .head_i (head),
      .left_i (lft),
      .right_i(rgt),
      .rec_o  (recs[i])
    );
  end

  // head compare during a scan: name for find, code for remove
  assign match = (mode_q == MODE_FIND)
               ? ({head.name_first, head.name_middle, head.name_tail} == nkey_q)
               : (head.code == key_q);
  assign hit   = match && !found_q;

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    k_d      = k_q;
    tot_d    = tot_q;
    mode_d   = mode_q;
    found_d  = found_q;
    res_d    = res_q;
    rst_st_d = rst_st_q;
    ov_d     = ov_q && !m_axis_tready;
    orec_d   = orec_q;
    ost_d    = ost_q;
    olast_d  = olast_q;
    ctl      = '{op: CELL_HOLD, phase: 1'b0, keep: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          mode_d  = s_axis_tuser;
          k_d     = '0;
          tot_d   = n_q;
          found_d = 1'b0;
          res_d   = '0;
          state_d = S_RESP;
          unique case (s_axis_tuser)
            MODE_APPEND: begin
              if (n_q == CntW'(TABLE_DEPTH)) begin
                rst_st_d = ST_FULL;
              end else begin
                ctl.op   = CELL_LOAD;
                n_d      = n_q + CntW'(1);
                rst_st_d = ST_OK;
              end
            end
            MODE_FIND, MODE_REMOVE: begin
              rst_st_d = ST_NOT_FOUND;
              if (n_q != '0) state_d = S_SCAN;
            end
            MODE_LIST: begin
              rst_st_d = ST_EMPTY;
              if (n_q != '0) state_d = S_SORT;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        ctl.op = CELL_ROTATE;
        if (hit) begin
          found_d  = 1'b1;
          res_d    = head;
          rst_st_d = ST_OK;
          if (mode_q == MODE_REMOVE) begin
            ctl.keep = 1'b0;
            n_d      = n_q - CntW'(1);
          end
        end
        k_d = k_q + CntW'(1);
        if (k_q == tot_q - CntW'(1)) state_d = S_RESP;
      end
      S_SORT: begin
        ctl.op    = CELL_SORT;
        ctl.phase = k_q[0];
        k_d       = k_q + CntW'(1);
        if (k_q == n_q - CntW'(1)) begin
          k_d     = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.op  = CELL_ROTATE;
          ov_d    = 1'b1;
          orec_d  = head;
          ost_d   = ST_LIST;
          olast_d = (k_q == n_q - CntW'(1));
          k_d     = k_q + CntW'(1);
          if (k_q == n_q - CntW'(1)) state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          orec_d  = res_q;
          ost_d   = rst_st_q;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      k_q     <= '0;
      tot_q   <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
      tot_q   <= tot_d;
      found_q <= found_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    res_q    <= res_d;
    rst_st_q <= rst_st_d;
    orec_q   <= orec_d;
    ost_q    <= ost_d;
    olast_q  <= olast_d;
    if (s_fire) begin
      key_q  <= s_axis_tdata[63:0];
      nkey_q <= {s_axis_tdata[127:64], s_axis_tdata[191:128], s_axis_tdata[223:192]};
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {7'd0, orec_q.total, orec_q.extra, orec_q.pay, orec_q.name_tail,
                          orec_q.name_middle, orec_q.name_first, orec_q.code};

endmodule

[sv/rtss_checker.sv]
// rtss_checker: port-level checks of the record table block
// bound to record_table_search_remove_sort_top; uses rtss_pkg status codes
`timescale 1ns / 1ps
module rtss_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [351:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import rtss_pkg::*;

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped under stall");

  // a taken command closes the input in the cycle after it
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after a command beat");

  // only defined status codes leave the block
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_LIST))
    else $error("undefined status");

  // single results always close their command
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_LIST) |-> m_axis_tlast)
    else $error("single result without last");

  // results that report no record carry zero data
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == ST_FULL) || (m_axis_tuser == ST_EMPTY) ||
    (m_axis_tuser == ST_NOT_FOUND)) |-> (m_axis_tdata == '0))
    else $error("nonzero data on a status-only result");

endmodule

bind record_table_search_remove_sort_top rtss_checker u_rtss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[sim/tb.sv]
// tb: self-checking bench for record_table_search_remove_sort_top
// scoreboard class predicts the record table; depends on rtss_pkg and the top
`timescale 1ns / 1ps
module tb;
  import rtss_pkg::*;

  localparam int DEPTH = 64;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [63:0]        code;
    logic [63:0]        nf;
    logic [63:0]        nm;
    logic [31:0]        nt;
    logic signed [39:0] pay;
    logic signed [39:0] extra;
  } entry_t;

  typedef struct packed {
    logic [2:0]   status;
    logic [351:0] data;
    logic         last;
  } beat_t;

  class table_scoreboard;
    entry_t rows[$];
    beat_t  pending[$];
    int     errors;

    function beat_t make_beat(logic [2:0] st, entry_t e, bit has_rec, bit last);
      beat_t b;
      logic signed [40:0] sum;
      b = '0;
      b.status = st;
      b.last = last;
      if (has_rec) begin
        sum = 41'(e.pay) + 41'(e.extra);
        b.data = {7'd0, sum, e.extra, e.pay, e.nt, e.nm, e.nf, e.code};
      end
      return b;
    endfunction

    // work out the result beats of one accepted command
    function void note_command(logic [1:0] mode, logic [303:0] d);
      entry_t e;
      entry_t z;
      entry_t t;
      logic signed [40:0] a;
      logic signed [40:0] b;
      bit hit;
      z = '0;
      e.code = d[63:0];
      e.nf = d[127:64];
      e.nm = d[191:128];
      e.nt = d[223:192];
      e.pay = d[263:224];
      e.extra = d[303:264];
      hit = 0;
      case (mode)
        MODE_APPEND: begin
          if (rows.size() >= DEPTH) pending.push_back(make_beat(ST_FULL, z, 0, 1));
          else begin
            rows.push_back(e);
            pending.push_back(make_beat(ST_OK, z, 0, 1));
          end
        end
        MODE_FIND: begin
          foreach (rows[i]) if (!hit && rows[i].nf == e.nf && rows[i].nm == e.nm
                                && rows[i].nt == e.nt) begin
            hit = 1;
            pending.push_back(make_beat(ST_OK, rows[i], 1, 1));
          end
          if (!hit) pending.push_back(make_beat(ST_NOT_FOUND, z, 0, 1));
        end
        MODE_REMOVE: begin
          for (int i = 0; i < rows.size(); i++) if (rows[i].code == e.code) begin
            pending.push_back(make_beat(ST_OK, rows[i], 1, 1));
            rows.delete(i);
            hit = 1;
            break;
          end
          if (!hit) pending.push_back(make_beat(ST_NOT_FOUND, z, 0, 1));
        end
        default: begin
          if (rows.size() == 0) pending.push_back(make_beat(ST_EMPTY, z, 0, 1));
          else begin
            // stable bubble sort, descending total
            for (int i = 0; i + 1 < rows.size(); i++)
              for (int j = 0; j + 1 < rows.size() - i; j++) begin
                a = 41'(rows[j].pay) + 41'(rows[j].extra);
                b = 41'(rows[j+1].pay) + 41'(rows[j+1].extra);
                if (a < b) begin
                  t = rows[j];
                  rows[j] = rows[j+1];
                  rows[j+1] = t;
                end
              end
            foreach (rows[i])
              pending.push_back(make_beat(ST_LIST, rows[i], 1, i == rows.size() - 1));
          end
        end
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [351:0] d, logic last);
      beat_t x;
      if (pending.size() == 0) begin
        $error("unexpected result beat status=%0d", st);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (st !== x.status) begin
        $error("status exp %0d got %0d", x.status, st); errors++;
      end
      if (d[63:0] !== x.data[63:0]) begin
        $error("out_code exp %h got %h", x.data[63:0], d[63:0]); errors++;
      end
      if (d[127:64] !== x.data[127:64]) begin
        $error("out_name_first exp %h got %h", x.data[127:64], d[127:64]); errors++;
      end
      if (d[191:128] !== x.data[191:128]) begin
        $error("out_name_middle exp %h got %h", x.data[191:128], d[191:128]); errors++;
      end
      if (d[223:192] !== x.data[223:192]) begin
        $error("out_name_tail exp %h got %h", x.data[223:192], d[223:192]); errors++;
      end
      if (d[263:224] !== x.data[263:224]) begin
        $error("pay_out exp %h got %h", x.data[263:224], d[263:224]); errors++;
      end
      if (d[303:264] !== x.data[303:264]) begin
        $error("extra_out exp %h got %h", x.data[303:264], d[303:264]); errors++;
      end
      if (d[344:304] !== x.data[344:304]) begin
        $error("income_total exp %h got %h", x.data[344:304], d[344:304]); errors++;
      end
      if (d[351:345] !== 7'd0) begin
        $error("tdata pad exp 0 got %h", d[351:345]); errors++;
      end
      if (last !== x.last) begin
        $error("last_item exp %0d got %0d", x.last, last); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [303:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = MODE_APPEND;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [351:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  table_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  longint cycles = 0;
  entry_t pool[$];

  always #1 clk_i = ~clk_i;

  record_table_search_remove_sort_top #(.TABLE_DEPTH(DEPTH)) dut (.*);

  // result monitor and random receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // drive one command beat, with random gaps before it; the block never takes
  // a beat in the cycle right after the previous one, so the first edge is free
  task automatic send_command(logic [1:0] mode, logic [303:0] d);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser <= mode;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(mode, d);
    s_axis_tvalid <= 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [303:0] pack_entry(entry_t e);
    return {e.extra, e.pay, e.nt, e.nm, e.nf, e.code};
  endfunction

  // fresh record; small totals collide often to exercise stable order
  function automatic entry_t rnd_entry();
    entry_t e;
    e.code = ($urandom_range(3) == 0) ? rnd64() : 64'($urandom_range(40));
    e.nf = ($urandom_range(3) == 0) ? rnd64() : 64'($urandom_range(40));
    e.nm = ($urandom_range(3) == 0) ? rnd64() : 64'($urandom_range(3));
    e.nt = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(3));
    case ($urandom_range(3))
      0: begin
        e.pay = {$urandom(), 8'($urandom())};
        e.extra = {$urandom(), 8'($urandom())};
      end
      1: begin
        e.pay = 40'(signed'($urandom_range(6)) - 3);
        e.extra = 40'(signed'($urandom_range(6)) - 3);
      end
      2: begin e.pay = 40'sh8000000000 + 40'($urandom_range(2));
               e.extra = 40'sh7fffffffff - 40'($urandom_range(2)); end
      default: begin e.pay = 40'($urandom_range(100000)); e.extra = 40'($urandom_range(1000)); end
    endcase
    return e;
  endfunction

  task automatic random_command();
    entry_t e;
    int k;
    e = rnd_entry();
    k = $urandom_range(99);
    if (k < 40 || sb.rows.size() < 2) begin
      send_command(MODE_APPEND, pack_entry(e));
    end else if (k < 65) begin
      // mostly look up a name held in the table
      if ($urandom_range(3) != 0)
        e = sb.rows[$urandom_range(sb.rows.size() - 1)];
      send_command(MODE_FIND, pack_entry(e));
    end else if (k < 88) begin
      if ($urandom_range(3) != 0)
        e.code = sb.rows[$urandom_range(sb.rows.size() - 1)].code;
      send_command(MODE_REMOVE, pack_entry(e));
    end else begin
      send_command(MODE_LIST, pack_entry(e));
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4 * DEPTH) @(posedge clk_i);
  endtask

  initial begin
    entry_t e;
    entry_t ones;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table cases
    ones = '1;
    send_command(MODE_LIST, '0);
    send_command(MODE_FIND, '0);
    send_command(MODE_REMOVE, pack_entry(ones));
    // extremes of every field, duplicate names and codes, equal totals
    send_command(MODE_APPEND, pack_entry(ones));
    e = '0;
    send_command(MODE_APPEND, pack_entry(e));
    e.pay = 40'sh7fffffffff; e.extra = 40'sh7fffffffff; e.code = 64'h41;
    send_command(MODE_APPEND, pack_entry(e));
    e.pay = 40'sh8000000000; e.extra = 40'sh8000000000; e.code = 64'h42;
    e.nf = 64'h4100_0000_0000_0042;
    send_command(MODE_APPEND, pack_entry(e));
    e.pay = 5; e.extra = -5; e.code = 64'h41; e.nf = 64'h41;
    send_command(MODE_APPEND, pack_entry(e));
    send_command(MODE_FIND, pack_entry(ones));
    send_command(MODE_FIND, pack_entry(e));
    e.nf = 64'h4100_0000_0000_0000;
    send_command(MODE_FIND, pack_entry(e));
    send_command(MODE_LIST, '0);
    send_command(MODE_REMOVE, pack_entry(e));
    send_command(MODE_REMOVE, 304'h43);
    send_command(MODE_LIST, '0);
    // fill the table to the top, then one append too many
    while (sb.rows.size() < DEPTH) send_command(MODE_APPEND, pack_entry(rnd_entry()));
    send_command(MODE_APPEND, pack_entry(ones));
    send_command(MODE_LIST, '0);
    // empty it again from the front
    while (sb.rows.size() > 0) send_command(MODE_REMOVE, pack_entry(sb.rows[0]));
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 88 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 88 : 0;
      if (ph == 3) begin send_idle_pct = 6; recv_stall_pct = 6; end
      for (int n = 0; n < 40; n++) begin
        random_command();
        if (n == 20) while (sb.pending.size() != 0) @(posedge clk_i);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[sim.f]
sv/rtss_pkg.sv
sv/rtss_cell.sv
sv/record_table_search_remove_sort_top.sv
sv/rtss_checker.sv
sim/tb.sv
